>>> hw/rtl/cdq_pkg.sv
// Package for the circular edge deque: command and status codes, controller
// states, command/status structs. No dependencies.
package cdq_pkg;

  localparam int DepthDefault = 64;
  localparam int EntryW = 32;

  typedef enum logic [3:0] {
    CMD_CLEAR = 4'd0, CMD_PUSH_F = 4'd1, CMD_PUSH_B = 4'd2, CMD_POP_F = 4'd3,
    CMD_POP_B = 4'd4, CMD_PEEK_F = 4'd5, CMD_PEEK_B = 4'd6, CMD_READ = 4'd7,
    CMD_FIND = 4'd8, CMD_SORT = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_FIND_RD, S_FIND_CMP, S_SORT_RDI, S_SORT_RDJ,
    S_SORT_CMP, S_SORT_WRJ, S_SORT_NEXT, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input word
    logic exec;       // simple command: update pointers, issue read
    logic rd_capture; // take read data as result
    logic find_init;
    logic find_rd;
    logic find_cmp;
    logic sort_init;
    logic sort_rdi;
    logic sort_rdj;
    logic sort_cmp;   // compare, write i-slot if swapping
    logic sort_wrj;   // write j-slot
    logic sort_next;  // advance i/j
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;    // simple command that needs a memory read
    logic is_find;
    logic is_sort;
    logic find_done;
    logic find_hit;
    logic sort_done;
    logic swap;
  } sts_t;

endpackage

>>> hw/rtl/circular_deque_with_weight_sort.sv
// Circular deque of edge entries with in-place weight sort (top level).
// Channels: s_axis carries one command word; m_axis returns one result word
// per command. Reset (rst, synchronous) empties the deque; entries are not
// cleared. After acceptance each command passes through S_EXEC; a peek or
// read that finds an entry adds S_RDWAIT, contains reads and compares each
// entry visited, and sort reads and compares each pair and writes back both
// slots when swapping, with one read and one write per cycle on the entry
// memory. A new command is taken in the cycle after the result word is
// accepted.
// One command is in flight at a time; s_axis_tready is low from acceptance
// until the result is taken. A stalled m_axis holds its word.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp.
module circular_deque_with_weight_sort import cdq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // cmd[3:0], orig, dest, weight, index, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, orig_out, dest_out, weight_out, found, count, pad
);

  localparam int CW = $clog2(DEPTH + 1);

  ctl_t ctl;
  sts_t sts;
  logic [1:0] status;
  logic [EntryW-1:0] rd_word;
  logic found;
  logic [CW-1:0] count;

  cdq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts(sts), .ctl(ctl)
  );

  cdq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cmd(s_axis_tdata[3:0]), .orig(s_axis_tdata[11:4]), .dest(s_axis_tdata[19:12]),
    .weight(s_axis_tdata[35:20]), .index(s_axis_tdata[41:36]),
    .status(status), .rd_word(rd_word), .found(found), .count(count)
  );

  assign m_axis_tdata = {6'd0, 7'(count), found, rd_word[15:0], rd_word[23:16],
                         rd_word[31:24], status};

endmodule

>>> hw/rtl/cdq_ctrl.sv
// Controller state machine for the circular edge deque.
// Depends on cdq_pkg.
module cdq_ctrl import cdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        priority if (sts.is_find) state_next = S_FIND_RD;
        else if (sts.is_sort)     state_next = S_SORT_NEXT;
        else if (sts.is_read)     state_next = S_RDWAIT;
        else                      state_next = S_DONE;
      end
      S_RDWAIT:    state_next = S_DONE;
      S_FIND_RD:   state_next = sts.find_done ? S_DONE : S_FIND_CMP;
      S_FIND_CMP:  state_next = sts.find_hit ? S_DONE : S_FIND_RD;
      S_SORT_NEXT: state_next = sts.sort_done ? S_DONE : S_SORT_RDI;
      S_SORT_RDI:  state_next = S_SORT_RDJ;
      S_SORT_RDJ:  state_next = S_SORT_CMP;
      S_SORT_CMP:  state_next = sts.swap ? S_SORT_WRJ : S_SORT_NEXT;
      S_SORT_WRJ:  state_next = S_SORT_NEXT;
      S_DONE:      if (out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_DONE);
    unique case (state)
      S_IDLE:      ctl.load = in_valid;
      S_EXEC: begin
        ctl.exec = 1'b1;
        ctl.find_init = sts.is_find;
        ctl.sort_init = sts.is_sort;
      end
      S_RDWAIT:    ctl.rd_capture = 1'b1;
      S_FIND_RD:   ctl.find_rd = 1'b1;
      S_FIND_CMP:  ctl.find_cmp = 1'b1;
      S_SORT_NEXT: ctl.sort_next = 1'b1;
      S_SORT_RDI:  ctl.sort_rdi = 1'b1;
      S_SORT_RDJ:  ctl.sort_rdj = 1'b1;
      S_SORT_CMP:  ctl.sort_cmp = 1'b1;
      S_SORT_WRJ:  ctl.sort_wrj = 1'b1;
      default: ;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC) else $error("accept lost");

endmodule

>>> hw/rtl/cdq_dp.sv
// Datapath for the circular edge deque: entry memory, head/fill, scan indices.
// Depends on cdq_pkg.
module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [3:0]  cmd,
  input  logic [7:0]  orig,
  input  logic [7:0]  dest,
  input  logic [15:0] weight,
  input  logic [5:0]  index,
  output logic [1:0]  status,
  output logic [EntryW-1:0] rd_word,
  output logic        found,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  logic [EntryW-1:0] mem [DEPTH];
  logic [EntryW-1:0] rdata;
  logic [EntryW-1:0] ent_i, key;
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic [3:0] cmd_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] si, sj;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata;
  logic          full, empty;
  logic [CW-1:0] pos;
  logic [AW-1:0] head_dec;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  always_comb begin
    unique case (cmd_q)
      CMD_PEEK_B: pos = fill - CW'(1);
      CMD_READ:   pos = CW'(idx_q);
      default:    pos = '0;
    endcase
  end

  always_comb begin
    sts.is_find   = (cmd_q == CMD_FIND);
    sts.is_sort   = (cmd_q == CMD_SORT);
    sts.is_read   = ((cmd_q == CMD_PEEK_F || cmd_q == CMD_PEEK_B) && !empty) ||
                    (cmd_q == CMD_READ && idx_q < IW'(fill));
    sts.find_done = (si >= fill);
    sts.find_hit  = (rdata == key);
    sts.sort_done = (sj + CW'(1) >= fill) && (si + CW'(2) >= fill);
    sts.swap      = (ent_i[15:0] < rdata[15:0]);
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = key; raddr = slot(head, pos);
    priority if (ctl.exec && cmd_q == CMD_PUSH_F && !full) begin
      we = 1'b1; waddr = head_dec;
    end else if (ctl.exec && cmd_q == CMD_PUSH_B && !full) begin
      we = 1'b1; waddr = slot(head, fill);
    end else if (ctl.sort_cmp && sts.swap) begin
      we = 1'b1; waddr = slot(head, si); wdata = rdata;
    end else if (ctl.sort_wrj) begin
      we = 1'b1; waddr = slot(head, sj); wdata = ent_i;
    end
    priority if (ctl.find_rd || ctl.sort_rdi) raddr = slot(head, si);
    else if (ctl.sort_rdj) raddr = slot(head, sj);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      key   <= {orig, dest, weight};
      idx_q <= IW'(index);
    end
    if (ctl.sort_rdj) ent_i <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; fill <= '0; status <= ST_OK; rd_word <= '0; found <= 1'b0;
      si <= '0; sj <= '0;
    end else begin
      if (ctl.load) begin
        status <= ST_OK; rd_word <= '0; found <= 1'b0;
      end
      if (ctl.exec) begin
        unique case (cmd_q)
          CMD_CLEAR: begin head <= '0; fill <= '0; end
          CMD_PUSH_F: if (full) status <= ST_FULL;
                      else begin head <= head_dec; fill <= fill + CW'(1); end
          CMD_PUSH_B: if (full) status <= ST_FULL; else fill <= fill + CW'(1);
          CMD_POP_F:  if (empty) status <= ST_EMPTY;
                      else begin head <= slot(head, CW'(1)); fill <= fill - CW'(1); end
          CMD_POP_B:  if (empty) status <= ST_EMPTY; else fill <= fill - CW'(1);
          CMD_PEEK_F, CMD_PEEK_B: if (empty) status <= ST_EMPTY;
          CMD_READ:   if (idx_q >= IW'(fill)) status <= ST_INDEX;
          default: ;
        endcase
      end
      if (ctl.rd_capture) rd_word <= rdata;
      if (ctl.find_init) si <= '0;
      if (ctl.find_cmp) begin
        if (sts.find_hit) found <= 1'b1;
        si <= si + CW'(1);
      end
      // sort: i outer, j inner; si/sj start at (0,0) so first next gives (0,1)
      if (ctl.sort_init) begin si <= '0; sj <= '0; end
      if (ctl.sort_next) begin
        if (sj + CW'(1) < fill) sj <= sj + CW'(1);
        else begin si <= si + CW'(1); sj <= si + CW'(2); end
      end
    end
  end

  assign count = fill;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH)) else $error("fill overflow");
  a_found_find: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> cmd_q == CMD_FIND) else $error("found outside search");
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    ctl.sort_rdi |-> si < sj) else $error("sort pair order");

endmodule
